FILE: sv/bata_pkg.sv
// Shared constants and types for the bridge converter trimmed averager.
`default_nettype none
package bata_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int COUNT_RESET     = 5;
	localparam int PAIR_LEN        = 2;
	localparam int TRIM_MIN_COUNT  = 3;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_ADD,
		ACC_TRIM_HI,
		ACC_TRIM_LO,
		ACC_CLEAR
	} acc_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIM_HI,
		ST_TRIM_LO,
		ST_LOAD,
		ST_DIV,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic burst_end;
		logic pair_mode;
	} acc_stat_t;

endpackage
`default_nettype wire

FILE: sv/bridge_adc_trimmed_averager.sv
// A closing word goes through two trim steps (skipped for a pair), a divider load, the bit-serial
//   divider steps, a done step and an output load, which waits for the output register to be free.
// Throughput: one word a cycle mid-burst; after a closing word s_axis_tready stays low until the
//   result is loaded into the output register, so no new word is taken while an average is formed.
// Reset (arst_n low, asynchronous): sample_count returns to 5, burst state clears,
//   output word is dropped, FSM goes idle.
`default_nettype none
module bridge_adc_trimmed_averager #(
	parameter int SAMPLE_BITS = bata_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = bata_pkg::COUNT_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// config: sample_count
	input  wire                                 cfg_we,
	input  wire  [COUNT_BITS-1:0]               cfg_wdata,
	// input word stream
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // [SAMPLE_BITS-1:0] raw_word
	// result stream
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata    // [SAMPLE_BITS-1:0] average
);
	import bata_pkg::*;

	localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
	localparam int TW       = ((SAMPLE_BITS + 7) / 8) * 8;

	// sample_count register, to be written only while idle; the block itself does not enforce this
	logic [COUNT_BITS-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= COUNT_BITS'(COUNT_RESET);
		else if (cfg_we) count_q <= cfg_wdata;
	end

	state_t                 state_q, state_d;
	acc_op_t                acc_op;
	acc_stat_t              acc_stat;
	logic [SUM_BITS-1:0]    acc_sum;
	logic                   in_take;
	logic                   div_start;
	logic                   div_done;
	logic [SUM_BITS-1:0]    div_quo;
	logic [COUNT_BITS-1:0]  den_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_data_q;
	logic                   out_free;
	logic                   out_load;
	logic [SAMPLE_BITS-1:0] avg_sat;

	assign in_take  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// Accumulator: sum, max, min, count; also applies the two trim subtractions.
	bata_accum #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (acc_op),
		.raw_word     (s_axis_tdata[SAMPLE_BITS-1:0]),
		.sample_count (count_q),
		.stat         (acc_stat),
		.sum          (acc_sum)
	);

	// Shared divider; numerator is latched at start so the burst can clear at once.
	bata_div #(
		.NUM_BITS (SUM_BITS),
		.DEN_BITS (COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (acc_sum),
		.denom    (den_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Divisor chosen on the closing word: 2 for a pair, else count minus the two extremes.
	always_ff @(posedge clk) begin
		if (in_take && acc_stat.burst_end) begin
			den_q  <= acc_stat.pair_mode ? COUNT_BITS'(PAIR_LEN)
			                             : count_q - COUNT_BITS'(PAIR_LEN);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take && acc_stat.burst_end)
					state_d = acc_stat.pair_mode ? ST_LOAD : ST_TRIM_HI;
			end
			ST_TRIM_HI: state_d = ST_TRIM_LO;
			ST_TRIM_LO: state_d = ST_LOAD;
			ST_LOAD:    state_d = ST_DIV;
			ST_DIV:     if (div_done) state_d = ST_PUT;
			ST_PUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		acc_op        = ACC_NONE;
		div_start     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) acc_op = ACC_ADD;
			end
			ST_TRIM_HI: acc_op = ACC_TRIM_HI;
			ST_TRIM_LO: acc_op = ACC_TRIM_LO;
			ST_LOAD: begin
				div_start = 1'b1;
				acc_op    = ACC_CLEAR;
			end
			ST_DIV: ;
			ST_PUT:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// quotient saturates to all ones above the sample range
	assign avg_sat = (|div_quo[SUM_BITS-1:SAMPLE_BITS]) ? '1 : div_quo[SAMPLE_BITS-1:0];

	// output register: holds a word while the block takes the next burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) out_data_q <= avg_sat;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TW'(out_data_q);

`ifndef SYNTH
	// divider finishes only while the sequencer waits on it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside ST_DIV");

	// a closing word in trim mode goes to the trim steps
	a_trim_path: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && acc_stat.burst_end && !acc_stat.pair_mode) |=> state_q == ST_TRIM_HI)
		else $error("closing word did not start trim");

	// a pair burst skips the trim steps
	a_pair_path: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && acc_stat.burst_end && acc_stat.pair_mode) |=> state_q == ST_LOAD)
		else $error("pair burst did not load divider");

	// a loaded result shows up on the output
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid)
		else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

FILE: sv/bata_accum.sv
// Burst accumulator: running sum, extremes, word count and trim steps.
`default_nettype none
module bata_accum #(
	parameter int SAMPLE_BITS = bata_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = bata_pkg::COUNT_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  bata_pkg::acc_op_t                    op,
	input  wire  [SAMPLE_BITS-1:0]               raw_word,
	input  wire  [COUNT_BITS-1:0]                sample_count,
	output bata_pkg::acc_stat_t                  stat,
	output logic [SAMPLE_BITS+COUNT_BITS-1:0]    sum
);
	import bata_pkg::*;

	localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
	localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [SUM_BITS-1:0]    sum_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [COUNT_BITS-1:0]  words_q;

	logic [SAMPLE_BITS-1:0] word_ob;
	logic [COUNT_BITS-1:0]  words_next;
	logic [COUNT_BITS-1:0]  burst_len;
	logic                   pair;

	// sign flip to offset binary
	assign word_ob    = raw_word ^ SIGN_BIT;
	assign words_next = words_q + COUNT_BITS'(1);
	assign pair       = sample_count < COUNT_BITS'(TRIM_MIN_COUNT);
	assign burst_len  = pair ? COUNT_BITS'(PAIR_LEN) : sample_count;

	// count wrap also closes a burst
	assign stat.burst_end = (words_next == '0) || (words_next >= burst_len);
	assign stat.pair_mode = pair;
	assign sum            = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			max_q   <= '0;
			min_q   <= '1;
			words_q <= '0;
		end else begin
			unique case (op)
				ACC_ADD: begin
					sum_q   <= sum_q + SUM_BITS'(word_ob);
					if (word_ob > max_q) max_q <= word_ob;
					if (word_ob < min_q) min_q <= word_ob;
					words_q <= words_next;
				end
				ACC_TRIM_HI: sum_q <= sum_q - SUM_BITS'(max_q);
				ACC_TRIM_LO: sum_q <= sum_q - SUM_BITS'(min_q);
				ACC_CLEAR: begin
					sum_q   <= '0;
					max_q   <= '0;
					min_q   <= '1;
					words_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/bata_div.sv
// Restoring divider, one quotient bit per cycle through a shared subtractor.
`default_nettype none
module bata_div #(
	parameter int NUM_BITS = bata_pkg::SAMPLE_BITS_DEF + bata_pkg::COUNT_BITS_DEF,
	parameter int DEN_BITS = bata_pkg::COUNT_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire  [NUM_BITS-1:0] numer,
	input  wire  [DEN_BITS-1:0] denom,
	output logic                done,
	output logic [NUM_BITS-1:0] quotient
);
	localparam int CW = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   diff;
	logic                fit;
	logic [DEN_BITS-1:0] rem_next;

	assign trial    = {rem_q, quo_q[NUM_BITS-1]};
	assign diff     = trial - {1'b0, den_q};
	assign fit      = trial >= {1'b0, den_q};
	assign rem_next = fit ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_BITS-2:0], fit};
			rem_q <= rem_next;
		end
	end

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for the bridge converter trimmed averager: directed and random bursts.
`default_nettype none
module tb;

	import bata_pkg::*;

	// Widths follow the block's defaults.
	localparam int SW    = SAMPLE_BITS_DEF;
	localparam int CW    = COUNT_BITS_DEF;
	localparam int SUMW  = SW + CW;              // running sum width (40)
	localparam int DW    = ((SW + 7) / 8) * 8;   // tdata width, padded to bytes
	localparam logic [SW-1:0] SIGN_BIT = {1'b1, {(SW-1){1'b0}}};
	localparam logic [SW-1:0] ALL_ONES = '1;
	localparam int MAX_COUNT = (1 << CW) - 1;
	// A closing word keeps the divider busy; give it some slack.
	localparam int DRAIN = SUMW + 24;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic          cfg_we = 1'b0;
	logic [CW-1:0] cfg_wdata = '0;

	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [DW-1:0] s_axis_tdata = '0;    // [SW-1:0] raw_word

	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [DW-1:0] m_axis_tdata;         // [SW-1:0] average

	bridge_adc_trimmed_averager DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Burst model: mirrors the block's accumulator, extremes and word count.
	// ---------------------------------------------------------------------
	logic [SUMW-1:0] burst_sum;
	logic [SW-1:0]   burst_hi;
	logic [SW-1:0]   burst_lo;
	logic [CW-1:0]   burst_words;
	logic [CW-1:0]   words_per_avg;

	// Averages the block still owes us, oldest first.
	logic [SW-1:0] pending_avg[$];

	int fail_count = 0;

	// Idle knobs, changed per phase.
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	// Long receiver hold-off request, consumed by the receiver process.
	int hold_req = 0;
	int hold_left = 0;

	function automatic void clear_burst_model();
		burst_sum   = '0;
		burst_hi    = '0;
		burst_lo    = ALL_ONES;   // first word always becomes the minimum
		burst_words = '0;
	endfunction

	// Fold one accepted word into the burst; queue an average when it closes.
	function automatic void burst_mean_update(input logic [SW-1:0] raw);
		logic [SW-1:0]   ofs;
		logic            pair;
		logic [CW-1:0]   blen;
		logic [SUMW-1:0] numer;
		logic [SUMW-1:0] divisor;
		logic [SUMW-1:0] quot;
		ofs  = raw ^ SIGN_BIT;        // two's complement -> offset binary
		pair = (words_per_avg < CW'(TRIM_MIN_COUNT));
		blen = pair ? CW'(PAIR_LEN) : words_per_avg;
		burst_sum = burst_sum + SUMW'(ofs);
		if (ofs > burst_hi) begin
			burst_hi = ofs;
		end
		if (ofs < burst_lo) begin
			burst_lo = ofs;
		end
		burst_words = burst_words + CW'(1);
		// A count lowered mid-burst makes the next word close it.
		if (burst_words != '0 && burst_words < blen) begin
			return;
		end
		if (pair) begin
			numer   = burst_sum;
			divisor = SUMW'(PAIR_LEN);
		end else begin
			numer   = burst_sum - SUMW'(burst_hi) - SUMW'(burst_lo);
			divisor = SUMW'(blen) - SUMW'(PAIR_LEN);
		end
		quot = numer / divisor;
		if (quot > SUMW'(ALL_ONES)) begin
			quot = SUMW'(ALL_ONES);   // saturate to the output range
		end
		pending_avg.push_back(quot[SW-1:0]);
		clear_burst_model();
	endfunction

	// ---------------------------------------------------------------------
	// Receiver: random stalls, plus an optional long hold-off.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Result checker: every accepted average against the oldest owed one.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		logic [SW-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_avg.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("unexpected average word %h", m_axis_tdata[SW-1:0]);
				end
			end else begin
				want = pending_avg.pop_front();
				if (m_axis_tdata[SW-1:0] !== want) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("average mismatch: expected %h, got %h",
							want, m_axis_tdata[SW-1:0]);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Shared stimulus helpers.
	// ---------------------------------------------------------------------

	// Offer one word, with a random gap first; valid stays high on return so
	// back-to-back words keep it up without a glitch.
	task automatic send_word(input logic [SW-1:0] raw);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= DW'(raw);
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		burst_mean_update(raw);
	endtask

	// Drop valid, wait for every owed average, then let the divider finish.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_avg.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN) @(posedge clk);
	endtask

	// Register write only with the block idle; burst state is left alone.
	task automatic write_count(input int val);
		settle();
		cfg_wdata <= CW'(val);
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		words_per_avg = CW'(val);
	endtask

	// Mix of rail values, values near zero and fully random words.
	function automatic logic [SW-1:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return ALL_ONES;
			2: return ~SIGN_BIT;          // most positive
			3: return SIGN_BIT;           // most negative
			4: return SW'($urandom_range(255));
			5: return ALL_ONES - SW'($urandom_range(255));
			default: return SW'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Tests.
	// ---------------------------------------------------------------------

	// Reset count of five, field extremes in one trimmed burst.
	task automatic test_reset_count();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		send_word('0);
		send_word(~SIGN_BIT);
		send_word(SIGN_BIT);
		send_word(ALL_ONES);
		send_word(24'h123456);
		settle();
	endtask

	// Counts 0, 1 and 2 all mean a two-word mean.
	task automatic test_pair_mode();
		write_count(1);
		send_word(~SIGN_BIT);
		send_word(~SIGN_BIT);   // top of the range
		write_count(2);
		send_word(SIGN_BIT);
		send_word(SIGN_BIT);    // bottom of the range
		write_count(0);
		send_word(24'h000001);
		send_word(ALL_ONES);
		settle();
	endtask

	// Smallest trimmed burst: divisor of one.
	task automatic test_three_words();
		write_count(TRIM_MIN_COUNT);
		send_word(24'h400000);
		send_word(24'hC00000);
		send_word(24'h000000);
		settle();
	endtask

	// Count rewritten with a burst partly taken.
	task automatic test_count_change();
		// Lowered below the words taken: next word closes, quotient saturates.
		write_count(6);
		repeat (4) send_word(~SIGN_BIT);
		write_count(TRIM_MIN_COUNT);
		send_word(~SIGN_BIT);
		// Dropped into pair mode: sum of four words over two saturates too.
		write_count(4);
		repeat (3) send_word(~SIGN_BIT);
		write_count(PAIR_LEN);
		send_word(~SIGN_BIT);
		// Raised mid-burst: burst just grows.
		write_count(TRIM_MIN_COUNT);
		send_word(24'h000010);
		send_word(24'hFFFFF0);
		write_count(5);
		send_word(24'h7FFF00);
		send_word(24'h800100);
		send_word(24'h000000);
		settle();
	endtask

	// Largest count, then cut short: the word after lowering closes the burst.
	task automatic test_max_count();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_count(MAX_COUNT);
		repeat (40) send_word(pick_word());
		write_count(TRIM_MIN_COUNT);
		send_word(pick_word());
		settle();
	endtask

	// Random counts and words under one idling profile.
	task automatic test_random_phase(input int src_pct, input int sink_pct,
			input int n_words);
		int sent;
		int seg;
		int cnt;
		sent = 0;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		while (sent < n_words) begin
			case ($urandom_range(9))
				0: cnt = $urandom_range(PAIR_LEN);          // pair mode, zero too
				1: cnt = $urandom_range(40, 9);
				default: cnt = $urandom_range(8, TRIM_MIN_COUNT);
			endcase
			// Often lands mid-burst, so count changes get exercised here too.
			write_count(cnt);
			seg = $urandom_range(30, 4);
			repeat (seg) send_word(pick_word());
			sent += seg;
		end
		settle();
	endtask

	// Receiver holds off for a long stretch while words keep coming; the
	// block fills and must stall its input.
	task automatic test_backpressure();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_count(PAIR_LEN);
		hold_req = 400;
		repeat (20) send_word(pick_word());
		settle();
	endtask

	// ---------------------------------------------------------------------
	// Sequence.
	// ---------------------------------------------------------------------
	initial begin
		words_per_avg = CW'(COUNT_RESET);
		clear_burst_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_count();
		test_pair_mode();
		test_three_words();
		test_count_change();
		test_max_count();
		test_random_phase(0, 0, 100);
		test_random_phase(66, 0, 100);
		test_random_phase(0, 66, 100);
		test_random_phase(9, 9, 100);
		test_backpressure();

		settle();
		if (fail_count == 0 && pending_avg.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#10_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
